// File: design/pot_pkg.sv
// Shared constants, types and arithmetic helpers of the perceptron online trainer.
`default_nettype none

package pot_pkg;

   // Fixed field widths of the item, the result and the registers
   localparam int NUM_INPUTS = 7;
   localparam int DIGIT_W    = 4;
   localparam int W_W        = 32;
   localparam int RATE_W     = 17;
   localparam int RATE_FRAC  = 16;
   localparam int NUM_W      = 24;
   localparam int CNT_OUT_W  = 11;

   // Internal datapath widths
   localparam int PROD_W   = W_W + DIGIT_W;
   localparam int ACC_W    = PROD_W + 4;
   localparam int MAG_W    = DIGIT_W + RATE_W + 1;
   localparam int STEP_W   = 31;
   localparam int NUM_ELEM = NUM_INPUTS + 1;
   localparam int NUM_PAIR = (NUM_ELEM + 1) / 2;
   localparam int NUM_TPAIR = (NUM_INPUTS + 1) / 2;

   // Parameter defaults
   localparam int FRACTION_BITS_DEF = 16;
   localparam int MAX_UPDATES_DEF   = 1024;

   // Register file
   localparam int APB_DW = 32;
   localparam int APB_AW = 3;
   localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(6554);
   localparam logic [NUM_W-1:0]  THRESH_RESET = '0;
   localparam logic REG_RATE   = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   // Control of one lane for one cycle
   typedef struct packed {
      logic load;
      logic calc;
      logic apply;
      logic up;
   } lane_ctrl_type;

   // Control of the merging stage
   typedef struct packed {
      logic sum1;
      logic sum2;
   } merge_ctrl_type;

   // What the merging stage found for the current weights
   typedef struct packed {
      logic pred_pos;
      logic label_pos;
   } merge_stat_type;

   // Power of ten used as the place value of a digit
   function automatic logic [NUM_W-1:0] pow10(input int k);
      logic [NUM_W-1:0] p;
      int j;
      p = NUM_W'(1);
      for (j = 0; j < k; j++) begin
         p = NUM_W'(p * NUM_W'(10));
      end
      return p;
   endfunction

   // Add or subtract a positive step and clamp to the signed 32-bit range.
   function automatic logic signed [W_W-1:0] sat_add(
      input logic signed [W_W-1:0] w,
      input logic [STEP_W-1:0]     step,
      input logic                  up
   );
      logic signed [W_W:0] wext;
      logic signed [W_W:0] sext;
      logic signed [W_W:0] sum;
      logic signed [W_W-1:0] res;
      wext = {w[W_W-1], w};
      sext = $signed({{(W_W+1-STEP_W){1'b0}}, step});
      sum  = up ? (wext + sext) : (wext - sext);
      if (sum[W_W] != sum[W_W-1]) begin
         res = sum[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
      end else begin
         res = sum[W_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/pot_if.sv
// Handshake interfaces for the sample channel and the result channel.
`default_nettype none

interface pot_req_if;
   logic                        valid;
   logic                        ready;
   logic [pot_pkg::DIGIT_W-1:0] digit_0;
   logic [pot_pkg::DIGIT_W-1:0] digit_1;
   logic [pot_pkg::DIGIT_W-1:0] digit_2;
   logic [pot_pkg::DIGIT_W-1:0] digit_3;
   logic [pot_pkg::DIGIT_W-1:0] digit_4;
   logic [pot_pkg::DIGIT_W-1:0] digit_5;
   logic [pot_pkg::DIGIT_W-1:0] digit_6;

   modport source (output valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                   digit_6, input ready);
   modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                   digit_6, output ready);
endinterface

interface pot_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [pot_pkg::W_W-1:0] weight_out_0;
   logic signed [pot_pkg::W_W-1:0] weight_out_1;
   logic signed [pot_pkg::W_W-1:0] weight_out_2;
   logic signed [pot_pkg::W_W-1:0] weight_out_3;
   logic signed [pot_pkg::W_W-1:0] weight_out_4;
   logic signed [pot_pkg::W_W-1:0] weight_out_5;
   logic signed [pot_pkg::W_W-1:0] weight_out_6;
   logic signed [pot_pkg::W_W-1:0] bias_out;
   logic [pot_pkg::CNT_OUT_W-1:0]  update_count;
   logic                          label_positive;
   logic                          gave_up;

   modport source (output valid, weight_out_0, weight_out_1, weight_out_2, weight_out_3,
                   weight_out_4, weight_out_5, weight_out_6, bias_out, update_count,
                   label_positive, gave_up, input ready);
   modport sink   (input valid, weight_out_0, weight_out_1, weight_out_2, weight_out_3,
                   weight_out_4, weight_out_5, weight_out_6, bias_out, update_count,
                   label_positive, gave_up, output ready);
endinterface

`default_nettype wire

// File: design/pot_lane.sv
// One lane: holds a weight and a digit, forms the product, place value term and update step.
`default_nettype none

module pot_lane #(
   parameter int FRACTION_BITS = pot_pkg::FRACTION_BITS_DEF,
   parameter int LANE_IDX      = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pot_pkg::lane_ctrl_type        ctrl,
   input  wire logic [pot_pkg::DIGIT_W-1:0]   digit_in,
   input  wire logic [pot_pkg::RATE_W-1:0]    rate,
   output logic signed [pot_pkg::W_W-1:0]     weight,
   output logic signed [pot_pkg::PROD_W-1:0]  prod,
   output logic [pot_pkg::NUM_W-1:0]          term
);

   localparam int SHL = (FRACTION_BITS >= pot_pkg::RATE_FRAC) ?
                        FRACTION_BITS - pot_pkg::RATE_FRAC : 0;
   localparam int SHR = (FRACTION_BITS >= pot_pkg::RATE_FRAC) ?
                        0 : pot_pkg::RATE_FRAC - FRACTION_BITS;
   localparam logic [pot_pkg::NUM_W-1:0] LANE_POW =
      pot_pkg::pow10(pot_pkg::NUM_INPUTS - 1 - LANE_IDX);
   localparam logic signed [pot_pkg::W_W-1:0] W_RESET =
      pot_pkg::W_W'(64'sd1 <<< FRACTION_BITS);

   logic [pot_pkg::DIGIT_W-1:0]          digit_ff;
   logic signed [pot_pkg::W_W-1:0]       weight_ff;
   logic signed [pot_pkg::W_W-1:0]       weight_in;
   logic signed [pot_pkg::PROD_W-1:0]    prod_ff;
   logic signed [pot_pkg::PROD_W-1:0]    prod_in;
   logic [pot_pkg::NUM_W-1:0]            term_ff;
   logic [pot_pkg::NUM_W-1:0]            term_in;
   logic [pot_pkg::STEP_W-1:0]           step_ff;
   logic [pot_pkg::STEP_W-1:0]           step_in;
   logic signed [pot_pkg::PROD_W:0]      mul_full;
   logic [pot_pkg::MAG_W-1:0]            mag;

   // Product of digit and weight, the digit's place value and the update step.
   always_comb begin
      mul_full = $signed({1'b0, digit_ff}) * $signed(weight_ff);
      prod_in  = mul_full[pot_pkg::PROD_W-1:0];
      term_in  = {{(pot_pkg::NUM_W-pot_pkg::DIGIT_W){1'b0}}, digit_ff} * LANE_POW;
      mag      = {{(pot_pkg::MAG_W-pot_pkg::DIGIT_W){1'b0}}, digit_ff} *
                 {{(pot_pkg::MAG_W-pot_pkg::RATE_W-1){1'b0}}, rate, 1'b0};
      step_in  = (pot_pkg::STEP_W'(mag) << SHL) >> SHR;
   end

   // Perceptron rule: move the weight toward the label by the step.
   always_comb begin
      weight_in = weight_ff;
      if (ctrl.apply) begin
         weight_in = pot_pkg::sat_add(weight_ff, step_ff, ctrl.up);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= W_RESET;
      end else begin
         weight_ff <= weight_in;
      end
   end

   // Payload registers of the lane.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         digit_ff <= digit_in;
      end
      if (ctrl.calc) begin
         prod_ff <= prod_in;
         term_ff <= term_in;
         step_ff <= step_in;
      end
   end

   assign weight = weight_ff;
   assign prod   = prod_ff;
   assign term   = term_ff;

endmodule

`default_nettype wire

// File: design/pot_merge.sv
// Merging stage: two-level registered adder trees for the dot product and the sample number.
`default_nettype none

module pot_merge (
   input  wire logic                                clock,
   input  wire pot_pkg::merge_ctrl_type             ctrl,
   input  wire logic signed [pot_pkg::PROD_W-1:0]   prod [pot_pkg::NUM_INPUTS],
   input  wire logic signed [pot_pkg::W_W-1:0]      bias,
   input  wire logic [pot_pkg::NUM_W-1:0]           term [pot_pkg::NUM_INPUTS],
   input  wire logic [pot_pkg::NUM_W-1:0]           threshold,
   output pot_pkg::merge_stat_type                  stat
);

   logic signed [pot_pkg::ACC_W-1:0] elem        [pot_pkg::NUM_ELEM];
   logic signed [pot_pkg::ACC_W-1:0] dot_pair_in [pot_pkg::NUM_PAIR];
   logic signed [pot_pkg::ACC_W-1:0] dot_pair_ff [pot_pkg::NUM_PAIR];
   logic [pot_pkg::NUM_W-1:0]        num_pair_in [pot_pkg::NUM_TPAIR];
   logic [pot_pkg::NUM_W-1:0]        num_pair_ff [pot_pkg::NUM_TPAIR];
   logic signed [pot_pkg::ACC_W-1:0] dot_total;
   logic [pot_pkg::NUM_W-1:0]        num_total;
   pot_pkg::merge_stat_type          stat_ff;
   pot_pkg::merge_stat_type          stat_in;

   // First level: sums of neighboring lanes, the bias taking the last slot.
   always_comb begin
      for (int i = 0; i < pot_pkg::NUM_INPUTS; i++) begin
         elem[i] = pot_pkg::ACC_W'(prod[i]);
      end
      elem[pot_pkg::NUM_INPUTS] = pot_pkg::ACC_W'(bias);
      for (int p = 0; p < pot_pkg::NUM_PAIR; p++) begin
         if (2 * p + 1 < pot_pkg::NUM_ELEM) begin
            dot_pair_in[p] = elem[2*p] + elem[2*p+1];
         end else begin
            dot_pair_in[p] = elem[2*p];
         end
      end
      for (int p = 0; p < pot_pkg::NUM_TPAIR; p++) begin
         if (2 * p + 1 < pot_pkg::NUM_INPUTS) begin
            num_pair_in[p] = term[2*p] + term[2*p+1];
         end else begin
            num_pair_in[p] = term[2*p];
         end
      end
   end

   // Second level: totals, sign of the weighted sum and the label compare.
   always_comb begin
      dot_total = '0;
      num_total = '0;
      for (int p = 0; p < pot_pkg::NUM_PAIR; p++) begin
         dot_total = dot_total + dot_pair_ff[p];
      end
      for (int p = 0; p < pot_pkg::NUM_TPAIR; p++) begin
         num_total = num_total + num_pair_ff[p];
      end
      stat_in.pred_pos  = !dot_total[pot_pkg::ACC_W-1];
      stat_in.label_pos = (num_total >= threshold);
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum1) begin
         dot_pair_ff <= dot_pair_in;
         num_pair_ff <= num_pair_in;
      end
      if (ctrl.sum2) begin
         stat_ff <= stat_in;
      end
   end

   assign stat = stat_ff;

endmodule

`default_nettype wire

// File: design/perceptron_online_trainer.sv
// Top level of the perceptron online trainer: sequencer, bias, registers and result stage.
//
//   Channel  Port group         Direction  Beat
//   sample   req_bus (sink)     in         seven decimal digits
//   result   rsp_bus (source)   out        weights, bias, update count, label, gave_up
//   config   csr_* (APB)        in/out     learning_rate at 0x0, label_threshold at 0x4
//
// A sample passes from acceptance to the result register through one predict round and
// one more per update (at most MAX_UPDATES); the next sample is taken only once the block
// is back in idle, after its result is loaded. Each predict round walks the lane products,
// the two levels of the merging adder tree and a decision cycle.
// Reset is synchronous and restores the weights to 1.0, the bias to -1.0 and the registers.
// A finished result waits in the output register; the next sample is taken meanwhile and
// its result is held back only while the register is still occupied.
`default_nettype none

module perceptron_online_trainer #(
   parameter int FRACTION_BITS = pot_pkg::FRACTION_BITS_DEF,
   parameter int MAX_UPDATES   = pot_pkg::MAX_UPDATES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   pot_req_if.sink                          req_bus,
   pot_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [pot_pkg::APB_AW-1:0]  csr_paddr,
   input  wire logic [pot_pkg::APB_DW-1:0]  csr_pwdata,
   output logic [pot_pkg::APB_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);

   localparam int CNT_W = $clog2(MAX_UPDATES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_UPDATES);
   localparam int SHL = (FRACTION_BITS >= pot_pkg::RATE_FRAC) ?
                        FRACTION_BITS - pot_pkg::RATE_FRAC : 0;
   localparam int SHR = (FRACTION_BITS >= pot_pkg::RATE_FRAC) ?
                        0 : pot_pkg::RATE_FRAC - FRACTION_BITS;
   localparam logic signed [pot_pkg::W_W-1:0] B_RESET =
      pot_pkg::W_W'(-(64'sd1 <<< FRACTION_BITS));

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PROD   = 3'd1;
   localparam logic [2:0] S_SUM1   = 3'd2;
   localparam logic [2:0] S_SUM2   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]                        state_ff;
   logic [2:0]                        state_in;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [CNT_W-1:0]                  cnt_in;
   logic signed [pot_pkg::W_W-1:0]    bias_ff;
   logic signed [pot_pkg::W_W-1:0]    bias_in;
   logic [pot_pkg::STEP_W-1:0]        bias_step;
   logic [pot_pkg::RATE_W-1:0]        rate_ff;
   logic [pot_pkg::RATE_W-1:0]        rate_in;
   logic [pot_pkg::NUM_W-1:0]         thresh_ff;
   logic [pot_pkg::NUM_W-1:0]         thresh_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [pot_pkg::W_W-1:0]    out_w_ff [pot_pkg::NUM_INPUTS];
   logic signed [pot_pkg::W_W-1:0]    out_b_ff;
   logic [pot_pkg::CNT_OUT_W-1:0]     out_cnt_ff;
   logic                              out_label_ff;
   logic                              out_gave_ff;

   logic                              accept;
   logic                              mismatch;
   logic                              do_update;
   logic                              out_load;
   logic                              csr_write;
   logic                              csr_idx;

   logic [pot_pkg::DIGIT_W-1:0]       digit_in [pot_pkg::NUM_INPUTS];
   logic signed [pot_pkg::W_W-1:0]    lane_w   [pot_pkg::NUM_INPUTS];
   logic signed [pot_pkg::PROD_W-1:0] lane_p   [pot_pkg::NUM_INPUTS];
   logic [pot_pkg::NUM_W-1:0]         lane_t   [pot_pkg::NUM_INPUTS];
   pot_pkg::lane_ctrl_type            lane_ctrl;
   pot_pkg::merge_ctrl_type           merge_ctrl;
   pot_pkg::merge_stat_type           mstat;

   // Handshake and decision terms.
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign mismatch      = (mstat.pred_pos != mstat.label_pos);
   assign do_update     = (state_ff == S_DECIDE) && mismatch && (cnt_ff != CNT_MAX);
   assign out_load      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // Digits of the sample beat, most significant in lane zero.
   assign digit_in[0] = req_bus.digit_0;
   assign digit_in[1] = req_bus.digit_1;
   assign digit_in[2] = req_bus.digit_2;
   assign digit_in[3] = req_bus.digit_3;
   assign digit_in[4] = req_bus.digit_4;
   assign digit_in[5] = req_bus.digit_5;
   assign digit_in[6] = req_bus.digit_6;

   // Lane and merge control.
   always_comb begin
      lane_ctrl.load  = accept;
      lane_ctrl.calc  = (state_ff == S_PROD);
      lane_ctrl.apply = do_update;
      lane_ctrl.up    = mstat.label_pos;
      merge_ctrl.sum1 = (state_ff == S_SUM1);
      merge_ctrl.sum2 = (state_ff == S_SUM2);
   end

   for (genvar g = 0; g < pot_pkg::NUM_INPUTS; g++) begin : g_lane
      pot_lane #(
         .FRACTION_BITS (FRACTION_BITS),
         .LANE_IDX      (g)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .digit_in (digit_in[g]),
         .rate     (rate_ff),
         .weight   (lane_w[g]),
         .prod     (lane_p[g]),
         .term     (lane_t[g])
      );
   end

   pot_merge u_merge (
      .clock     (clock),
      .ctrl      (merge_ctrl),
      .prod      (lane_p),
      .bias      (bias_ff),
      .term      (lane_t),
      .threshold (thresh_ff),
      .stat      (mstat)
   );

   // Sequencer: one predict round is product, two tree levels and a decision.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PROD;
            end
         end
         S_PROD:   state_in = S_SUM1;
         S_SUM1:   state_in = S_SUM2;
         S_SUM2:   state_in = S_DECIDE;
         S_DECIDE: state_in = do_update ? S_PROD : S_DONE;
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Update counter and bias, which follows the same rule as the weights with a unit input.
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (do_update) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      bias_step = (pot_pkg::STEP_W'({rate_ff, 1'b0}) << SHL) >> SHR;
      bias_in   = bias_ff;
      if (do_update) begin
         bias_in = pot_pkg::sat_add(bias_ff, bias_step, mstat.label_pos);
      end
   end

   // Configuration registers.
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx   = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_comb begin
      rate_in    = rate_ff;
      thresh_in  = thresh_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         pot_pkg::REG_RATE: begin
            csr_prdata = pot_pkg::APB_DW'(rate_ff);
            if (csr_write) begin
               rate_in = csr_pwdata[pot_pkg::RATE_W-1:0];
            end
         end
         pot_pkg::REG_THRESH: begin
            csr_prdata = pot_pkg::APB_DW'(thresh_ff);
            if (csr_write) begin
               thresh_in = csr_pwdata[pot_pkg::NUM_W-1:0];
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         bias_ff      <= B_RESET;
         rate_ff      <= pot_pkg::RATE_RESET;
         thresh_ff    <= pot_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bias_ff      <= bias_in;
         rate_ff      <= rate_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register, loaded once the previous result beat has left.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_w_ff     <= lane_w;
         out_b_ff     <= bias_ff;
         out_cnt_ff   <= pot_pkg::CNT_OUT_W'(cnt_ff);
         out_label_ff <= mstat.label_pos;
         out_gave_ff  <= mismatch;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.weight_out_0   = out_w_ff[0];
   assign rsp_bus.weight_out_1   = out_w_ff[1];
   assign rsp_bus.weight_out_2   = out_w_ff[2];
   assign rsp_bus.weight_out_3   = out_w_ff[3];
   assign rsp_bus.weight_out_4   = out_w_ff[4];
   assign rsp_bus.weight_out_5   = out_w_ff[5];
   assign rsp_bus.weight_out_6   = out_w_ff[6];
   assign rsp_bus.bias_out       = out_b_ff;
   assign rsp_bus.update_count   = out_cnt_ff;
   assign rsp_bus.label_positive = out_label_ff;
   assign rsp_bus.gave_up        = out_gave_ff;

   // An accepted sample always starts a predict round.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_PROD)
      else $error("accepted sample did not start a predict round");

   // The update counter never passes the cap.
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> cnt_ff <= CNT_MAX)
      else $error("update counter passed the cap");

   // The bias moves only in an update cycle.
   a_bias_hold: assert property (@(posedge clock) disable iff (reset)
      !do_update |=> $stable(bias_ff))
      else $error("bias changed outside an update");

   // Giving up means the full number of updates was spent.
   a_gave_up_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_gave_ff |-> out_cnt_ff == pot_pkg::CNT_OUT_W'(MAX_UPDATES))
      else $error("gave_up reported before the cap");

endmodule

`default_nettype wire

// File: tb/pot_trainer_checker.sv
// Checker of the perceptron online trainer: watches the channels, predicts each result, compares.
module pot_trainer_checker import pot_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pot_req_if                req_mon,
   pot_rsp_if                rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [APB_AW-1:0] csr_paddr,
   input  logic [APB_DW-1:0] csr_pwdata,
   input  logic [APB_DW-1:0] csr_prdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = FRACTION_BITS_DEF;
   localparam int UPDATE_CAP = MAX_UPDATES_DEF;
   localparam longint W_HI = 64'sd2147483647;
   localparam longint W_LO = -64'sd2147483648;
   localparam logic [APB_AW-1:0] ADDR_RATE   = APB_AW'(4 * int'(REG_RATE));
   localparam logic [APB_AW-1:0] ADDR_THRESH = APB_AW'(4 * int'(REG_THRESH));

   typedef logic [NUM_INPUTS-1:0][DIGIT_W-1:0] digit_vec_type;

   // What training on one sample leaves behind
   typedef struct packed {
      logic [NUM_INPUTS-1:0][W_W-1:0] weights;
      logic [W_W-1:0]                 bias;
      logic [CNT_OUT_W-1:0]           count;
      logic                           label_pos;
      logic                           gave_up;
   } trained_type;

   // Mirror of the trainer state and of its registers
   logic signed [W_W-1:0] weight_q [NUM_INPUTS];
   logic signed [W_W-1:0] bias_q;
   logic [RATE_W-1:0]     rate_q;
   logic [NUM_W-1:0]      thresh_q;

   trained_type trained_queue [$];
   int          errors = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Clamp a wide sum to the signed 32-bit range.
   function automatic logic signed [W_W-1:0] clamp_w(input longint v);
      if (v > W_HI) begin
         return W_W'(W_HI);
      end
      if (v < W_LO) begin
         return W_W'(W_LO);
      end
      return W_W'(v);
   endfunction

   // Bring a step from the rate's fraction bits to the weights' fraction bits.
   function automatic longint rate_step(input longint mag);
      if (FRAC_BITS >= RATE_FRAC) begin
         return mag <<< (FRAC_BITS - RATE_FRAC);
      end
      return mag >>> (RATE_FRAC - FRAC_BITS);
   endfunction

   // Sign of the weighted digit sum plus bias under the current weights.
   function automatic bit sum_positive(input digit_vec_type d);
      longint acc;
      acc = longint'(bias_q);
      for (int i = 0; i < NUM_INPUTS; i++) begin
         acc += longint'(d[i]) * longint'(weight_q[i]);
      end
      return acc >= 0;
   endfunction

   // Train on one sample until the prediction matches the label or the cap is hit.
   task automatic train_sample(input digit_vec_type d, output trained_type res);
      longint number;
      longint stp;
      bit     label_pos;
      bit     pred_pos;
      int     updates;
      number = 0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         number = number * 10 + longint'(d[i]);
      end
      label_pos = number >= longint'(thresh_q);
      pred_pos  = sum_positive(d);
      updates   = 0;
      while (pred_pos != label_pos && updates < UPDATE_CAP) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            stp = rate_step(longint'(d[i]) * 2 * longint'(rate_q));
            weight_q[i] = clamp_w(longint'(weight_q[i]) + (label_pos ? stp : -stp));
         end
         stp    = rate_step(2 * longint'(rate_q));
         bias_q = clamp_w(longint'(bias_q) + (label_pos ? stp : -stp));
         updates++;
         pred_pos = sum_positive(d);
      end
      for (int i = 0; i < NUM_INPUTS; i++) begin
         res.weights[i] = weight_q[i];
      end
      res.bias      = bias_q;
      res.count     = CNT_OUT_W'(updates);
      res.label_pos = label_pos;
      res.gave_up   = pred_pos != label_pos;
   endtask

   // Compare the result beat on the channel with the oldest prediction.
   task automatic compare_result(input trained_type want);
      logic signed [W_W-1:0] got_w [NUM_INPUTS];
      got_w[0] = rsp_mon.weight_out_0;
      got_w[1] = rsp_mon.weight_out_1;
      got_w[2] = rsp_mon.weight_out_2;
      got_w[3] = rsp_mon.weight_out_3;
      got_w[4] = rsp_mon.weight_out_4;
      got_w[5] = rsp_mon.weight_out_5;
      got_w[6] = rsp_mon.weight_out_6;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         if (got_w[i] !== want.weights[i]) begin
            $error("weight_out_%0d: expected %0d, got %0d", i,
                   $signed(want.weights[i]), got_w[i]);
            errors++;
         end
      end
      if (rsp_mon.bias_out !== want.bias) begin
         $error("bias_out: expected %0d, got %0d", $signed(want.bias), rsp_mon.bias_out);
         errors++;
      end
      if (rsp_mon.update_count !== want.count) begin
         $error("update_count: expected %0d, got %0d", want.count, rsp_mon.update_count);
         errors++;
      end
      if (rsp_mon.label_positive !== want.label_pos) begin
         $error("label_positive: expected %0d, got %0d", want.label_pos,
                rsp_mon.label_positive);
         errors++;
      end
      if (rsp_mon.gave_up !== want.gave_up) begin
         $error("gave_up: expected %0d, got %0d", want.gave_up, rsp_mon.gave_up);
         errors++;
      end
   endtask

   // Everything is sampled at the rising edge, before the block's outputs move.
   always @(posedge clock) begin
      trained_type   want;
      trained_type   fresh;
      digit_vec_type d;
      logic [APB_DW-1:0] reg_value;
      if (reset) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            weight_q[i] = W_W'(1 << FRAC_BITS);
         end
         bias_q   = -W_W'(1 << FRAC_BITS);
         rate_q   = RATE_RESET;
         thresh_q = THRESH_RESET;
         trained_queue.delete();
      end else begin
         // Register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_RATE) begin
               rate_q = csr_pwdata[RATE_W-1:0];
            end else if (csr_paddr == ADDR_THRESH) begin
               thresh_q = csr_pwdata[NUM_W-1:0];
            end
         end
         // Register reads return the value last written
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready &&
             (csr_paddr == ADDR_RATE || csr_paddr == ADDR_THRESH)) begin
            reg_value = (csr_paddr == ADDR_RATE) ? APB_DW'(rate_q) : APB_DW'(thresh_q);
            if (csr_prdata !== reg_value) begin
               $error("csr_prdata at 0x%0h: expected %0d, got %0d", csr_paddr, reg_value,
                      csr_prdata);
               errors++;
            end
         end
         // Result beats are matched first so that an early one is caught.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (trained_queue.size() == 0) begin
               $error("result beat arrived with no sample outstanding");
               errors++;
            end else begin
               want = trained_queue.pop_front();
               compare_result(want);
            end
         end
         // Each accepted sample trains the mirror and queues its result.
         if (req_mon.valid && req_mon.ready) begin
            d[0] = req_mon.digit_0;
            d[1] = req_mon.digit_1;
            d[2] = req_mon.digit_2;
            d[3] = req_mon.digit_3;
            d[4] = req_mon.digit_4;
            d[5] = req_mon.digit_5;
            d[6] = req_mon.digit_6;
            train_sample(d, fresh);
            trained_queue.push_back(fresh);
         end
      end
      fail_count    <= errors;
      pending_count <= trained_queue.size();
   end

endmodule

// File: tb/perceptron_online_trainer_test.sv
// Top of the perceptron online trainer testbench: clock, reset, stimulus and verdict.
module perceptron_online_trainer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pot_pkg::*;

   localparam int LIMIT_CYCLES = 30_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_DECIMAL  = 9999999;
   localparam logic [APB_AW-1:0] ADDR_RATE   = APB_AW'(4 * int'(REG_RATE));
   localparam logic [APB_AW-1:0] ADDR_THRESH = APB_AW'(4 * int'(REG_THRESH));

   typedef logic [NUM_INPUTS-1:0][DIGIT_W-1:0] digit_vec_type;
   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [APB_AW-1:0] csr_paddr;
   logic [APB_DW-1:0] csr_pwdata;
   logic [APB_DW-1:0] csr_prdata;
   logic              csr_pready;

   int  mismatch_total;
   int  results_owed;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  thresh_now = 0;
   bit  hold_flag = 1'b0;

   pot_req_if req_ch ();
   pot_rsp_if rsp_ch ();

   perceptron_online_trainer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pot_trainer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (mismatch_total),
      .pending_count (results_owed)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off each time hold_flag toggles.
   initial begin
      bit hold_seen;
      int hold_left;
      hold_seen = 1'b0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_flag != hold_seen) begin
            hold_seen = hold_flag;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic digit_vec_type digits_of(input int number);
      digit_vec_type d;
      for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
         d[i] = DIGIT_W'(number % 10);
         number = number / 10;
      end
      return d;
   endfunction

   // Mostly decimal samples, some near the threshold, some with digits above nine.
   function automatic digit_vec_type random_sample();
      digit_vec_type d;
      int pick;
      int near;
      pick = $urandom_range(99);
      if (pick < 15) begin
         near = (thresh_now > MAX_DECIMAL) ? MAX_DECIMAL : thresh_now;
         near = near + $urandom_range(20) - 10;
         if (near < 0) begin
            near = 0;
         end else if (near > MAX_DECIMAL) begin
            near = MAX_DECIMAL;
         end
         d = digits_of(near);
      end else if (pick < 35) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            d[i] = DIGIT_W'($urandom_range(15));
         end
      end else begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            d[i] = DIGIT_W'($urandom_range(9));
         end
      end
      return d;
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct  = 72;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct  = 0;
            recv_stall_pct = 72;
         end
         default: begin
            send_idle_pct  = 12;
            recv_stall_pct = 12;
         end
      endcase
   endtask

   // Offer one sample beat, with random gaps ahead of it, and wait until it is taken.
   task automatic send_sample(input digit_vec_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.digit_0 <= d[0];
      req_ch.digit_1 <= d[1];
      req_ch.digit_2 <= d[2];
      req_ch.digit_3 <= d[3];
      req_ch.digit_4 <= d[4];
      req_ch.digit_5 <= d[5];
      req_ch.digit_6 <= d[6];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [APB_AW-1:0] addr,
                             input logic [APB_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change both registers while the trainer is idle, then read them back.
   task automatic set_config(input int rate, input int thresh);
      wait_drained();
      csr_access(1'b1, ADDR_RATE, APB_DW'(rate));
      csr_access(1'b1, ADDR_THRESH, APB_DW'(thresh));
      csr_access(1'b0, ADDR_RATE, '0);
      csr_access(1'b0, ADDR_THRESH, '0);
      thresh_now = thresh;
   endtask

   task automatic run_phase(input int rate, input int thresh, input idle_mode_type mode,
                            input int count);
      set_config(rate, thresh);
      set_idle(mode);
      repeat (count) send_sample(random_sample());
   endtask

   // Stimulus
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.digit_0 <= '0;
      req_ch.digit_1 <= '0;
      req_ch.digit_2 <= '0;
      req_ch.digit_3 <= '0;
      req_ch.digit_4 <= '0;
      req_ch.digit_5 <= '0;
      req_ch.digit_6 <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      set_idle(IDLE_NONE);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers come out of reset with their defaults.
      csr_access(1'b0, ADDR_RATE, '0);
      csr_access(1'b0, ADDR_THRESH, '0);

      // Digit extremes at the reset settings, zero threshold
      send_sample(digits_of(0));
      send_sample(digits_of(MAX_DECIMAL));
      send_sample({NUM_INPUTS{4'hF}});
      send_sample(28'hF0F0F0F);
      send_sample(28'h0F0F0F0);

      // Samples right at and around the top decimal threshold
      set_config(int'(RATE_RESET), MAX_DECIMAL);
      send_sample(digits_of(MAX_DECIMAL));
      send_sample(digits_of(MAX_DECIMAL - 1));
      send_sample({NUM_INPUTS{4'hF}});
      send_sample(digits_of(0));

      // Rate above 1.0
      set_config(131071, 5000000);
      send_sample(digits_of(4999999));
      send_sample(digits_of(5000000));
      send_sample(digits_of(0));
      send_sample(digits_of(MAX_DECIMAL));

      // Rate of exactly 1.0 with a threshold no sample can reach
      set_config(65536, 16777215);
      send_sample({NUM_INPUTS{4'hF}});
      send_sample(digits_of(1234567));

      // Zero rate: a wrong prediction can never be fixed, so the cap is hit.
      set_config(0, 0);
      send_sample(digits_of(1234567));
      send_sample({NUM_INPUTS{4'hF}});

      // Smallest nonzero rate
      set_config(1, 0);
      send_sample(digits_of(MAX_DECIMAL));
      send_sample(digits_of(0));

      // Random phases, each with its own settings and idling
      run_phase(6554, 5000000, IDLE_NONE, 200);
      run_phase(32768, 1234567, IDLE_SEND, 200);
      run_phase(1000, 8000000, IDLE_RECV, 200);

      // Long receiver hold-off while samples keep coming, so the input backs up.
      set_idle(IDLE_NONE);
      hold_flag <= ~hold_flag;
      repeat (12) send_sample(random_sample());
      wait_drained();

      run_phase($urandom_range(65535, 1024), $urandom_range(MAX_DECIMAL), IDLE_BOTH, 150);
      run_phase(65536, MAX_DECIMAL, IDLE_NONE, 100);
      run_phase($urandom_range(131071, 65536), $urandom_range(16777215), IDLE_SEND, 150);
      run_phase(6554, 4000000, IDLE_BOTH, 250);

      wait_drained();
      if (mismatch_total == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/pot_pkg.sv
design/pot_if.sv
design/pot_lane.sv
design/pot_merge.sv
design/perceptron_online_trainer.sv
tb/pot_trainer_checker.sv
tb/perceptron_online_trainer_test.sv
